// ===== rtl/biu_pkg.sv =====
package biu_pkg;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_STEP   = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   // step codes
   localparam logic [1:0] STEP_ONE   = 2'd1;
   localparam logic [1:0] STEP_TWO   = 2'd2;
   localparam logic [1:0] STEP_THREE = 2'd3;

   // reciprocal constants for division by three and by nine
   localparam logic [7:0]  RECIP_THREE       = 8'd171;
   localparam int          RECIP_THREE_SHIFT = 9;
   localparam logic [11:0] RECIP_NINE        = 12'd3641;
   localparam int          RECIP_NINE_SHIFT  = 15;

   typedef struct packed {
      logic       command;
      logic [6:0] col;
      logic [6:0] row;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // quotient of an 8-bit value by a step of one, two or three
   function automatic logic [7:0] div_step(input logic [7:0] v, input logic [1:0] st);
      logic [15:0] prod;
      logic [7:0]  q;
      prod = 16'(v) * 16'(RECIP_THREE);
      case (st)
         STEP_TWO:   q = v >> 1;
         STEP_THREE: q = 8'(prod >> RECIP_THREE_SHIFT);
         default:    q = v;
      endcase
      return q;
   endfunction

   // weighted sum over step squared, truncated and saturated
   function automatic logic [7:0] norm_div(input logic [11:0] s, input logic [1:0] st);
      logic [23:0] prod;
      logic [11:0] q;
      prod = 24'(s) * 24'(RECIP_NINE);
      case (st)
         STEP_TWO:   q = s >> 2;
         STEP_THREE: q = 12'(prod >> RECIP_NINE_SHIFT);
         default:    q = s;
      endcase
      return (q > 12'd255) ? 8'd255 : q[7:0];
   endfunction

endpackage

// ===== rtl/bilinear_integer_upscaler.sv =====
// Bilinear upscaler over a stored coarse RGB grid. A write beat (command 0) stores one
// sample at (col,row) of the grid and completes in the cycle it is accepted, so writes
// stream at one per cycle while no read is busy; writes outside the current grid are
// dropped. A read beat (command 1) asks for output pixel (col,row) and gives one
// response beat: the four neighbor samples are fetched one per cycle through the single
// port of the sample memory, then the weighted sums are normalized by step squared. A
// read holds the input through fetch (four memory reads, one trailing accumulate) and
// normalize; the next beat is taken in the normalize cycle when the response register
// is free, not before. The response register decouples the two sides. The grid is
// sample_step times coarser than the out_width by out_height frame. The sample memory
// holds MAX_WIDTH*MAX_HEIGHT entries, has no reset and no clearing pass: reading a
// sample never written gives undefined data. Registers may only change while idle.
module bilinear_integer_upscaler
   import biu_pkg::*;
#(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   // register writes
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // frame size caps, limited to what the 8-bit registers can express
   localparam logic [7:0] WIDTH_CAP  = 8'((MAX_WIDTH  > 255) ? 255 : MAX_WIDTH);
   localparam logic [7:0] HEIGHT_CAP = 8'((MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FETCH = 3'b010,
      S_NORM  = 3'b100
   } state_type;

   // configuration registers
   logic [1:0] step_ff, step_in;
   logic [7:0] width_ff, width_in;
   logic [7:0] height_ff, height_in;

   // control
   state_type  state_ff, state_in;
   logic [2:0] tap_ff, tap_in;

   // read coordinates and fractions
   logic [6:0] x0_ff, x0_in, x1_ff, x1_in;
   logic [6:0] y0_ff, y0_in, y1_ff, y1_in;
   logic [1:0] kx_ff, kx_in, ky_ff, ky_in;

   // per-channel accumulators, at most 255 * 9
   logic [11:0] acc_r_ff, acc_r_in;
   logic [11:0] acc_g_ff, acc_g_in;
   logic [11:0] acc_b_ff, acc_b_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // sample memory
   logic [23:0]       store_mem [DEPTH];
   logic [23:0]       rd_data_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;

   // effective configuration
   logic [1:0] step_eff;
   logic [7:0] width_eff, height_eff;
   logic [7:0] gw_last, gh_last;

   logic       accept;
   logic       out_free;
   logic       in_grid;
   logic [7:0] col_q, row_q, col_r, row_r;
   logic [7:0] x0_p1, y0_p1;
   logic [6:0] x0_c, y0_c;
   logic [6:0] tap_x, tap_y;
   logic [1:0] prev_tap;
   logic [1:0] wx, wy;
   logic [3:0] weight;

   // zero step acts as one, frame size clamped to one..max
   always_comb begin
      step_eff   = (step_ff == 2'd0) ? STEP_ONE : step_ff;
      width_eff  = (width_ff == 8'd0) ? 8'd1 :
                   ((width_ff > WIDTH_CAP) ? WIDTH_CAP : width_ff);
      height_eff = (height_ff == 8'd0) ? 8'd1 :
                   ((height_ff > HEIGHT_CAP) ? HEIGHT_CAP : height_ff);
      gw_last    = div_step(width_eff - 8'd1, step_eff);
      gh_last    = div_step(height_eff - 8'd1, step_eff);
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_NORM) && out_free);
   assign accept    = req_valid && req_ready;

   assign in_grid = ({1'b0, req_data.col} <= gw_last) && ({1'b0, req_data.row} <= gh_last);
   assign mem_we  = accept && (req_data.command == CMD_WRITE) && in_grid;

   // neighbor coordinates of a read, clamped to the grid
   always_comb begin
      col_q = div_step({1'b0, req_data.col}, step_eff);
      row_q = div_step({1'b0, req_data.row}, step_eff);
      col_r = {1'b0, req_data.col} - 8'(col_q * step_eff);
      row_r = {1'b0, req_data.row} - 8'(row_q * step_eff);
      if (col_q > gw_last) begin
         x0_c  = gw_last[6:0];
         kx_in = step_eff;
      end else begin
         x0_c  = col_q[6:0];
         kx_in = col_r[1:0];
      end
      if (row_q > gh_last) begin
         y0_c  = gh_last[6:0];
         ky_in = step_eff;
      end else begin
         y0_c  = row_q[6:0];
         ky_in = row_r[1:0];
      end
      x0_p1 = {1'b0, x0_c} + 8'd1;
      y0_p1 = {1'b0, y0_c} + 8'd1;
      x0_in = x0_c;
      y0_in = y0_c;
      x1_in = (x0_p1 > gw_last) ? gw_last[6:0] : x0_p1[6:0];
      y1_in = (y0_p1 > gh_last) ? gh_last[6:0] : y0_p1[6:0];
   end

   // tap order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
   always_comb begin
      tap_x = tap_ff[0] ? x1_ff : x0_ff;
      tap_y = tap_ff[1] ? y1_ff : y0_ff;
      if (state_ff == S_FETCH) begin
         mem_addr = ADDR_W'(int'(tap_y) * MAX_WIDTH + int'(tap_x));
      end else begin
         mem_addr = ADDR_W'(int'(req_data.row) * MAX_WIDTH + int'(req_data.col));
      end
   end

   // weight of the tap whose data arrives this cycle
   always_comb begin
      prev_tap = 2'(tap_ff - 3'd1);
      wx       = prev_tap[0] ? kx_ff : 2'(step_eff - kx_ff);
      wy       = prev_tap[1] ? ky_ff : 2'(step_eff - ky_ff);
      weight   = 4'(wx * wy);
   end

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      acc_r_in     = acc_r_ff;
      acc_g_in     = acc_g_ff;
      acc_b_in     = acc_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE, S_NORM: begin
            if (state_ff == S_NORM && out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in.red   = norm_div(acc_r_ff, step_eff);
               rsp_data_in.green = norm_div(acc_g_ff, step_eff);
               rsp_data_in.blue  = norm_div(acc_b_ff, step_eff);
               state_in          = S_IDLE;
            end
            if (accept && req_data.command == CMD_READ) begin
               state_in = S_FETCH;
               tap_in   = 3'd0;
               acc_r_in = 12'd0;
               acc_g_in = 12'd0;
               acc_b_in = 12'd0;
            end
         end
         S_FETCH: begin
            // data of the previous tap returns from the registered read in the cycle after its address
            if (tap_ff != 3'd0) begin
               acc_r_in = acc_r_ff + 12'(rd_data_ff[23:16] * weight);
               acc_g_in = acc_g_ff + 12'(rd_data_ff[15:8] * weight);
               acc_b_in = acc_b_ff + 12'(rd_data_ff[7:0] * weight);
            end
            if (tap_ff == 3'd4) begin
               state_in = S_NORM;
            end
            tap_in = tap_ff + 3'd1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // register writes, indexes past the list are dropped
   always_comb begin
      step_in   = step_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STEP:   step_in   = csr_wdata[1:0];
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tap_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_ONE;
         width_ff     <= 8'd128;
         height_ff    <= 8'd128;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      acc_r_ff    <= acc_r_in;
      acc_g_ff    <= acc_g_in;
      acc_b_ff    <= acc_b_in;
      rsp_data_ff <= rsp_data_in;
      if (accept && req_data.command == CMD_READ) begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         y0_ff <= y0_in;
         y1_ff <= y1_in;
         kx_ff <= kx_in;
         ky_ff <= ky_in;
      end
   end

   // single-port sample memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
      rd_data_ff <= store_mem[mem_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a response only appears out of the normalize step
   a_rsp_from_norm: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_NORM))
      else $error("response raised outside normalize");

   // no beat is taken while the memory port is busy fetching
   a_no_accept_in_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> !req_ready)
      else $error("request taken during fetch");

   // fetch walks the four taps plus one trailing accumulate
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> (tap_ff <= 3'd4))
      else $error("tap counter out of range");

   // the store is written only by an accepted write beat
   a_write_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (accept && state_ff != S_FETCH))
      else $error("sample store written without a write beat");
`endif

endmodule
